[hw/rtl/lrgd_pkg.sv]
// Shared constants, widths and register codes for the regression trainer.
package lrgd_pkg;

    localparam int MAX_POINTS = 128;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int DATA_W     = 32;
    localparam int LR_W       = 24;
    localparam int LR_SHIFT   = 24;
    localparam int EP_W       = 6;
    localparam int LOSS_W     = 31;

    // iterative divider: magnitude dividend over magnitude divisor
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 32;

    // iterative square root
    localparam int SQ_IN_W    = 64;
    localparam int SQ_RT_W    = SQ_IN_W / 2;

    localparam logic [LR_W-1:0] LR_RESET  = LR_W'(16777);
    localparam logic [EP_W-1:0] EPC_RESET = EP_W'(26);
    localparam int              PCT       = 100;

    localparam logic CFG_LR  = 1'b0;
    localparam logic CFG_EPC = 1'b1;

endpackage

[hw/rtl/lrgd_ram.sv]
// Generic single-port-write, registered-read RAM.
module lrgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/lrgd_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module lrgd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lrgd_pkg::DVD_W-1:0] i_dvd,
    input  logic [lrgd_pkg::DVS_W-1:0] i_dvs,
    output logic                      o_done,
    output logic [lrgd_pkg::DVD_W-1:0] o_quo
);
    import lrgd_pkg::*;

    localparam int DC_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [DC_W-1:0]  r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_dif;
    logic             w_ge;

    assign w_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_dvs};
    assign w_dif = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_dvd  <= i_dvd;
                r_dvs  <= i_dvs;
                r_cnt  <= DC_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_dif[DVS_W-1:0] : w_sh[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
                r_cnt <= r_cnt - DC_W'(1);
                if (r_cnt == DC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;
endmodule

[hw/rtl/lrgd_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module lrgd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lrgd_pkg::SQ_IN_W-1:0] i_val,
    output logic                        o_done,
    output logic [lrgd_pkg::SQ_RT_W-1:0] o_root
);
    import lrgd_pkg::*;

    localparam int SC_W = $clog2(SQ_RT_W + 1);
    localparam int RM_W = SQ_RT_W + 1;

    logic               r_busy;
    logic               r_done;
    logic [SC_W-1:0]    r_cnt;
    logic [RM_W-1:0]    r_rem;
    logic [SQ_RT_W-1:0] r_root;
    logic [SQ_IN_W-1:0] r_v;
    logic [RM_W+1:0]    w_rn;
    logic [RM_W+1:0]    w_tr;
    logic               w_ge;

    assign w_rn = {r_rem, r_v[SQ_IN_W-1 -: 2]};
    assign w_tr = {1'b0, r_root, 2'b01};
    assign w_ge = w_rn >= w_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_root <= '0;
                r_v    <= i_val;
                r_cnt  <= SC_W'(SQ_RT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? RM_W'(w_rn - w_tr) : RM_W'(w_rn);
                r_root <= {r_root[SQ_RT_W-2:0], w_ge};
                r_v    <= {r_v[SQ_IN_W-3:0], 2'b00};
                r_cnt  <= r_cnt - SC_W'(1);
                if (r_cnt == SC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[hw/rtl/linear_regression_gd_trainer.sv]
// Top level: point store plus gradient-descent training sequencer.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------------
//  in       | in        | i_in_valid / o_in_stall | i_sample_x, i_sample_y, i_last_sample
//  out      | out       | o_out_valid/i_out_stall | o_epoch_index, o_intercept, o_slope,
//           |           |                         | o_loss, o_error_rate, o_points_dropped,
//           |           |                         | o_last_result
//  cfg      | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Loading: one point per cycle into the x/y RAMs while idle.
// Training: per epoch, a step pass (a point loop plus 4 divides) when the epoch is not the
//   first and the last RMSE is nonzero, then a report pass (one divide for each point with
//   nonzero y, on the shared bit-serial divider), then two divides and a sqrt.
// Reset (synchronous, active low) clears control, model and counts; RAM contents are not
//   cleared. A stalled report holds; the next report waits in its state until it can load.
module linear_regression_gd_trainer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lrgd_pkg::DATA_W-1:0]  i_sample_x,
    input  logic signed [lrgd_pkg::DATA_W-1:0]  i_sample_y,
    input  logic                                i_last_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lrgd_pkg::EP_W-1:0]           o_epoch_index,
    output logic signed [lrgd_pkg::DATA_W-1:0]  o_intercept,
    output logic signed [lrgd_pkg::DATA_W-1:0]  o_slope,
    output logic [lrgd_pkg::LOSS_W-1:0]         o_loss,
    output logic signed [lrgd_pkg::DATA_W-1:0]  o_error_rate,
    output logic                                o_points_dropped,
    output logic                                o_last_result,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [lrgd_pkg::LR_W-1:0]           i_cfg_data
);
    import lrgd_pkg::*;

    localparam int SA_W = DATA_W + CNT_W;      // sum of residuals / error terms
    localparam int SB_W = 48 + CNT_W;          // sum of x*r >> frac
    localparam int PA_W = DATA_W + LR_W + 1;   // delta times rate
    localparam int ER_W = DATA_W + 6;          // |r| * 100

    typedef enum logic [4:0] {
        S_IDLE, S_EPOCH, S_RD, S_MUL, S_RES, S_MUL2, S_ACC, S_EACC, S_NEXT,
        S_DWAIT, S_GMA, S_GMB, S_GDA, S_GDB, S_UPM, S_UPD, S_SQ, S_SQW, S_ERR, S_OUT
    } t_state;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DVD_W-1:0] mag(input logic signed [65:0] v);
        return v[65] ? DVD_W'(-v) : DVD_W'(v);
    endfunction

    t_state r_state, r_after;

    logic [LR_W-1:0]            r_lr;
    logic [EP_W-1:0]            r_epc;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_ovf;
    logic signed [DATA_W-1:0]   r_a, r_b;
    logic [EP_W-1:0]            r_ep;
    logic                       r_pass;     // 0: gradient pass, 1: report pass
    logic [ADDR_W-1:0]          r_idx;

    logic signed [DATA_W-1:0]   r_x, r_y, r_res;
    logic signed [63:0]         r_prod, r_prod2;
    logic [ER_W-1:0]            r_err;
    logic signed [SA_W-1:0]     r_sa, r_se;
    logic signed [SB_W-1:0]     r_sb;
    logic [63:0]                r_ss;
    logic signed [DATA_W-1:0]   r_ma, r_mb, r_da, r_db;
    logic signed [PA_W-1:0]     r_pa, r_pb;
    logic [LOSS_W-1:0]          r_rmse;
    logic signed [DATA_W-1:0]   r_erate;
    logic signed [64:0]         r_quo;

    logic                       r_div_start, r_div_neg;
    logic [DVD_W-1:0]           r_div_dvd;
    logic [DVS_W-1:0]           r_div_dvs;
    logic                       r_sq_start;
    logic [SQ_IN_W-1:0]         r_sq_in;

    logic                       r_ovalid;
    logic [EP_W-1:0]            r_o_ep;
    logic signed [DATA_W-1:0]   r_o_a, r_o_b, r_o_err;
    logic [LOSS_W-1:0]          r_o_loss;
    logic                       r_o_drop, r_o_last;

    logic [DATA_W-1:0]          w_rd_x, w_rd_y;
    logic                       w_we;
    logic signed [DATA_W-1:0]   w_resid;
    logic [DATA_W-1:0]          w_rabs;
    logic [64:0]                w_ss_sum;
    logic                       w_last;
    logic                       w_div_done, w_sq_done;
    logic [DVD_W-1:0]           w_div_quo;
    logic [SQ_RT_W-1:0]         w_sq_root;

    // point store
    assign w_we = (r_state == S_IDLE) && i_in_valid && (r_cnt < CNT_W'(MAX_POINTS));

    lrgd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_sample_x),
        .i_raddr (r_idx),
        .o_rdata (w_rd_x)
    );

    lrgd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_sample_y),
        .i_raddr (r_idx),
        .o_rdata (w_rd_y)
    );

    lrgd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_dvd   (r_div_dvd),
        .i_dvs   (r_div_dvs),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    lrgd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_val   (r_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    // residual: a + floor(b*x / 2^F) - y, saturated
    assign w_resid  = sat32(66'(r_a) + 66'(r_prod >>> FRAC_BITS) - 66'(r_y));
    assign w_rabs   = DATA_W'(r_res[DATA_W-1] ? -(33'(r_res)) : 33'(r_res));
    assign w_ss_sum = {1'b0, r_ss} + {1'b0, r_prod2};
    assign w_last   = (CNT_W'(r_idx) + CNT_W'(1)) == r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lr        <= LR_RESET;
            r_epc       <= EPC_RESET;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_a         <= '0;
            r_b         <= '0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LR) begin
                    r_lr <= i_cfg_data;
                end else begin
                    r_epc <= i_cfg_data[EP_W-1:0];
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (r_cnt < CNT_W'(MAX_POINTS)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_sample) begin
                            r_a     <= '0;
                            r_b     <= '0;
                            r_ep    <= '0;
                            r_state <= S_EPOCH;
                        end
                    end
                end
                S_EPOCH: begin
                    // first epoch and a perfect fit both skip the update
                    r_idx   <= '0;
                    r_sa    <= '0;
                    r_sb    <= '0;
                    r_se    <= '0;
                    r_ss    <= '0;
                    r_pass  <= (r_ep == '0) || (r_rmse == '0);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_x     <= w_rd_x;
                    r_y     <= w_rd_y;
                    r_prod  <= r_b * $signed(w_rd_x);
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_res   <= w_resid;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod2 <= r_pass ? r_res * r_res : r_x * r_res;
                    r_err   <= ER_W'(w_rabs) * ER_W'(PCT);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_pass) begin
                        r_sa    <= r_sa + SA_W'(r_res);
                        r_sb    <= r_sb + SB_W'(r_prod2 >>> FRAC_BITS);
                        r_state <= S_NEXT;
                    end else begin
                        r_ss <= w_ss_sum[64] ? '1 : w_ss_sum[63:0];
                        if (r_y != '0) begin
                            r_div_start <= 1'b1;
                            r_div_dvd   <= DVD_W'(r_err) << FRAC_BITS;
                            r_div_dvs   <= DVS_W'(mag(66'(r_y)));
                            r_div_neg   <= r_y[DATA_W-1];
                            r_after     <= S_EACC;
                            r_state     <= S_DWAIT;
                        end else begin
                            r_se    <= r_se + SA_W'(sat32(66'(r_err)));
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_EACC: begin
                    r_se    <= r_se + SA_W'(sat32(66'(r_quo)));
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!w_last) begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_state <= S_RD;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_dvs   <= DVS_W'(r_cnt);
                        r_state     <= S_DWAIT;
                        if (!r_pass) begin
                            r_div_dvd <= mag(66'(r_sa));
                            r_div_neg <= r_sa[SA_W-1];
                            r_after   <= S_GMA;
                        end else begin
                            r_div_dvd <= r_ss;
                            r_div_neg <= 1'b0;
                            r_after   <= S_SQ;
                        end
                    end
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_quo   <= r_div_neg ? -$signed({1'b0, w_div_quo})
                                             : $signed({1'b0, w_div_quo});
                        r_state <= r_after;
                    end
                end
                S_GMA: begin
                    r_ma        <= r_quo[DATA_W-1:0];
                    r_div_start <= 1'b1;
                    r_div_dvd   <= mag(66'(r_sb));
                    r_div_dvs   <= DVS_W'(r_cnt);
                    r_div_neg   <= r_sb[SB_W-1];
                    r_after     <= S_GMB;
                    r_state     <= S_DWAIT;
                end
                S_GMB: begin
                    r_mb        <= sat32(66'(r_quo));
                    r_div_start <= 1'b1;
                    r_div_dvd   <= mag(66'(r_ma)) << FRAC_BITS;
                    r_div_dvs   <= DVS_W'(r_rmse);
                    r_div_neg   <= r_ma[DATA_W-1];
                    r_after     <= S_GDA;
                    r_state     <= S_DWAIT;
                end
                S_GDA: begin
                    r_da        <= sat32(66'(r_quo));
                    r_div_start <= 1'b1;
                    r_div_dvd   <= mag(66'(r_mb)) << FRAC_BITS;
                    r_div_dvs   <= DVS_W'(r_rmse);
                    r_div_neg   <= r_mb[DATA_W-1];
                    r_after     <= S_GDB;
                    r_state     <= S_DWAIT;
                end
                S_GDB: begin
                    r_db    <= sat32(66'(r_quo));
                    r_state <= S_UPM;
                end
                S_UPM: begin
                    r_pa    <= r_da * $signed({1'b0, r_lr});
                    r_pb    <= r_db * $signed({1'b0, r_lr});
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_a     <= sat32(66'(r_a) - 66'(r_pa >>> LR_SHIFT));
                    r_b     <= sat32(66'(r_b) - 66'(r_pb >>> LR_SHIFT));
                    r_pass  <= 1'b1;
                    r_idx   <= '0;
                    r_ss    <= '0;
                    r_se    <= '0;
                    r_state <= S_RD;
                end
                S_SQ: begin
                    r_sq_start <= 1'b1;
                    r_sq_in    <= r_quo[SQ_IN_W-1:0];
                    r_state    <= S_SQW;
                end
                S_SQW: begin
                    if (w_sq_done) begin
                        r_rmse      <= w_sq_root[SQ_RT_W-1] ? '1 : w_sq_root[LOSS_W-1:0];
                        r_div_start <= 1'b1;
                        r_div_dvd   <= mag(66'(r_se));
                        r_div_dvs   <= DVS_W'(r_cnt);
                        r_div_neg   <= r_se[SA_W-1];
                        r_after     <= S_ERR;
                        r_state     <= S_DWAIT;
                    end
                end
                S_ERR: begin
                    r_erate <= sat32(66'(r_quo));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // load only once the previous report has been taken
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_o_ep   <= r_ep;
                        r_o_a    <= r_a;
                        r_o_b    <= r_b;
                        r_o_loss <= r_rmse;
                        r_o_err  <= r_erate;
                        r_o_drop <= r_ovf;
                        r_o_last <= (r_ep == r_epc);
                        if (r_ep == r_epc) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ep    <= r_ep + EP_W'(1);
                            r_state <= S_EPOCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_epoch_index    = r_o_ep;
    assign o_intercept      = r_o_a;
    assign o_slope          = r_o_b;
    assign o_loss           = r_o_loss;
    assign o_error_rate     = r_o_err;
    assign o_points_dropped = r_o_drop;
    assign o_last_result    = r_o_last;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && i_out_stall) |=> (r_state == S_OUT))
        else $error("report loaded over a stalled one");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_train_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EPOCH) |-> (r_cnt != '0))
        else $error("training started with no points");
`endif
endmodule
